// ===== hdl/ccr_pkg.sv =====
// Clock-control register block: shared types, constants and divider lookups.
// No dependencies; used by clock_control_register_block.
package ccr_pkg;

  typedef enum logic [0:0] {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_OFFSET = 2'd1,
    STATUS_BAD_WIDTH  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_MUL,
    S_DONE
  } state_t;

  typedef struct packed {
    kind_t       kind;
    logic [11:0] address;
    logic [2:0]  access_size;
    logic [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    status_t     status;
    logic        clock_changed;
    logic        backup_reset;
    logic [31:0] core_clock_hz;
    logic [31:0] bus1_clock_hz;
  } rsp_t;

  // register file word numbers (byte offset / 4)
  localparam logic [9:0] WORD_CTRL = 10'd0;
  localparam logic [9:0] WORD_CFG  = 10'd1;
  localparam logic [9:0] WORD_BDCR = 10'd8;
  localparam logic [9:0] WORD_CSR  = 10'd9;

  localparam logic [31:0] READY_BITS    = 32'h2A02_0002;
  localparam logic [31:0] SWS_BITS      = 32'h0000_000C;
  localparam logic [31:0] CLOCK_BITS    = 32'h003D_07F3;
  localparam logic [31:0] LOW_READY_BIT = 32'h0000_0002;
  localparam int          BACKUP_RESET_POS = 16;

  localparam logic [25:0] OSC_DEFAULT_HZ = 26'd8000000;

  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  localparam logic [1:0] SEL_HSE = 2'd1;
  localparam logic [1:0] SEL_PLL = 2'd2;

  // ahb prescaler as a right shift: /1 x8, then /2,4,8,16,64,128,256,512
  function automatic logic [3:0] ahb_shift(input logic [3:0] code);
    logic [3:0] s;
    unique case (code)
      4'd8:    s = 4'd1;
      4'd9:    s = 4'd2;
      4'd10:   s = 4'd3;
      4'd11:   s = 4'd4;
      4'd12:   s = 4'd6;
      4'd13:   s = 4'd7;
      4'd14:   s = 4'd8;
      4'd15:   s = 4'd9;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

  // apb1 prescaler as a right shift: /1 x4, then /2,4,8,16
  function automatic logic [2:0] apb_shift(input logic [2:0] code);
    logic [2:0] s;
    unique case (code)
      3'd4:    s = 3'd1;
      3'd5:    s = 3'd2;
      3'd6:    s = 3'd3;
      3'd7:    s = 3'd4;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/clock_control_register_block.sv =====
// Clock-control register block top level: shadow word memory, access FSM, rate calculation.
// Depends on ccr_pkg.
//
// Usage:
//   req channel (req_valid/req_ready/req): one bus access, read or write of 1, 2 or 4 bytes.
//   rsp channel (rsp_valid/rsp_ready/rsp): one result per access with read data, status,
//   clock-changed and backup-reset pulses, and the core and bus-1 clock rates in Hz.
//   APB port: oscillator frequencies at 0x0 (internal) and 0x4 (external), 26 bits each.
// Steps: the memory read happens at the request transfer; then merge and write-back, rate
//   multiply and output load follow in turn, each in a registered step.
// Access order: the access FSM holds one access at a time across the shadow memory
//   (one read port, one write port) and the rate multiplier.
// Stall: the response sits in an output register; a new request is taken while it
//   waits, and that access holds in its last step until the output register frees.
// Reset: per-word valid bits clear so every shadow word counts as zero, both
//   oscillator registers return to 8 MHz, no response is pending.
module clock_control_register_block #(
  parameter int REGION_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  ccr_pkg::req_t      req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output ccr_pkg::rsp_t      rsp,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int WORD_COUNT = (REGION_BYTES + 3) / 4;
  localparam int IDX_W      = $clog2(WORD_COUNT);

  ccr_pkg::state_t state, state_next;

  logic [25:0] int_osc;
  logic [25:0] ext_osc;
  logic [25:0] hsi_hz;
  logic [25:0] hse_hz;

  logic [31:0]           mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] word_valid;
  logic [31:0]           mem_q;
  logic                  mem_q_valid;
  logic                  mem_we;
  logic [IDX_W-1:0]      rd_idx;
  logic [IDX_W-1:0]      wr_idx;

  ccr_pkg::req_t req_q;
  logic [9:0]    word_no;
  logic [4:0]    shift;
  logic [31:0]   cur;
  logic [31:0]   rword;
  logic [31:0]   old_word;
  logic [31:0]   mask;
  logic [31:0]   merged;
  logic [31:0]   new_word;
  logic          bad_offset;
  logic          bad_width;
  logic          do_write;

  ccr_pkg::status_t res_status;
  logic [31:0]      res_rdata;
  logic             res_changed;
  logic             res_bkp;
  logic [31:0]      pend_rdata;
  ccr_pkg::status_t pend_status;
  logic             pend_changed;
  logic             pend_bkp;

  logic [31:0] cfg_word;
  logic [25:0] mul_a;
  logic [4:0]  mul_b;
  logic [3:0]  pll_m;
  logic [30:0] sys_hz;
  logic [30:0] core_hz;
  logic [30:0] bus1_hz;
  logic        rsp_load;

  // configuration port
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {6'd0, ext_osc} : {6'd0, int_osc};

  always_ff @(posedge clk) begin
    if (rst) begin
      int_osc <= ccr_pkg::OSC_DEFAULT_HZ;
      ext_osc <= ccr_pkg::OSC_DEFAULT_HZ;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        ext_osc <= pwdata[25:0];
      end else begin
        int_osc <= pwdata[25:0];
      end
    end
  end

  assign hsi_hz = (int_osc == 26'd0) ? ccr_pkg::OSC_DEFAULT_HZ : int_osc;
  assign hse_hz = (ext_osc == 26'd0) ? ccr_pkg::OSC_DEFAULT_HZ : ext_osc;

  // fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    rsp_load   = 1'b0;
    unique case (state)
      ccr_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = ccr_pkg::S_READ;
        end
      end
      ccr_pkg::S_READ: begin
        state_next = ccr_pkg::S_MUL;
      end
      ccr_pkg::S_MUL: begin
        state_next = ccr_pkg::S_DONE;
      end
      ccr_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_load   = 1'b1;
          state_next = ccr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ccr_pkg::S_IDLE;
      end
    endcase
  end

  // request capture
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  // shadow word memory
  assign rd_idx = req.address[IDX_W+1:2];
  assign wr_idx = req_q.address[IDX_W+1:2];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= new_word;
    end
    mem_q       <= mem[rd_idx];
    mem_q_valid <= word_valid[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= '0;
    end else if (mem_we) begin
      word_valid[wr_idx] <= 1'b1;
    end
  end

  // read-modify-write
  assign word_no    = req_q.address[11:2];
  assign shift      = {req_q.address[1:0], 3'b000};
  assign cur        = mem_q_valid ? mem_q : 32'd0;
  assign bad_offset = req_q.address >= 12'(REGION_BYTES);
  assign bad_width  = (req_q.access_size != ccr_pkg::SIZE_BYTE) &&
                      (req_q.access_size != ccr_pkg::SIZE_HALF) &&
                      (req_q.access_size != ccr_pkg::SIZE_WORD);
  assign do_write   = !bad_offset && !bad_width && (req_q.kind == ccr_pkg::KIND_WRITE);
  assign mem_we     = (state == ccr_pkg::S_READ) && do_write;

  always_comb begin
    rword = cur;
    if (word_no == ccr_pkg::WORD_CTRL) begin
      rword = cur | ccr_pkg::READY_BITS;
    end else if (word_no == ccr_pkg::WORD_CFG) begin
      rword = cur & ~ccr_pkg::SWS_BITS;
      if (cur[1:0] == ccr_pkg::SEL_PLL) begin
        rword[3] = 1'b1;
      end else if (cur[1:0] == ccr_pkg::SEL_HSE) begin
        rword[2] = 1'b1;
      end
    end else if (word_no == ccr_pkg::WORD_BDCR || word_no == ccr_pkg::WORD_CSR) begin
      rword = cur | ccr_pkg::LOW_READY_BIT;
    end
  end

  always_comb begin
    old_word = cur;
    if (word_no == ccr_pkg::WORD_CTRL) begin
      old_word = cur & ~ccr_pkg::READY_BITS;
    end else if (word_no == ccr_pkg::WORD_CFG) begin
      old_word = cur & ~ccr_pkg::SWS_BITS;
    end
    mask = ((req_q.access_size == ccr_pkg::SIZE_BYTE) ? 32'h0000_00FF : 32'h0000_FFFF)
           << shift;
    if (req_q.access_size == ccr_pkg::SIZE_WORD) begin
      merged = req_q.write_data;
    end else begin
      merged = (old_word & ~mask) | ((req_q.write_data << shift) & mask);
    end
    new_word = merged;
    if (word_no == ccr_pkg::WORD_CTRL) begin
      new_word = merged & ~ccr_pkg::READY_BITS;
    end else if (word_no == ccr_pkg::WORD_CFG) begin
      new_word = merged & ~ccr_pkg::SWS_BITS;
    end
  end

  always_comb begin
    res_rdata   = 32'd0;
    res_changed = 1'b0;
    res_bkp     = 1'b0;
    priority if (bad_offset) begin
      res_status = ccr_pkg::STATUS_BAD_OFFSET;
    end else if (bad_width) begin
      res_status = ccr_pkg::STATUS_BAD_WIDTH;
    end else begin
      res_status = ccr_pkg::STATUS_OK;
      if (req_q.kind == ccr_pkg::KIND_READ) begin
        if (req_q.access_size == ccr_pkg::SIZE_BYTE) begin
          res_rdata = (rword >> shift) & 32'h0000_00FF;
        end else if (req_q.access_size == ccr_pkg::SIZE_HALF) begin
          res_rdata = (rword >> shift) & 32'h0000_FFFF;
        end else begin
          res_rdata = rword;
        end
      end else begin
        res_changed = (word_no == ccr_pkg::WORD_CFG) &&
                      (((old_word ^ new_word) & ccr_pkg::CLOCK_BITS) != 32'd0);
        res_bkp     = (word_no == ccr_pkg::WORD_BDCR) &&
                      new_word[ccr_pkg::BACKUP_RESET_POS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ccr_pkg::S_READ) begin
      pend_rdata   <= res_rdata;
      pend_status  <= res_status;
      pend_changed <= res_changed;
      pend_bkp     <= res_bkp;
    end
  end

  // config word copy for the rate calculation
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_word <= 32'd0;
    end else if (mem_we && word_no == ccr_pkg::WORD_CFG) begin
      cfg_word <= new_word;
    end
  end

  // system clock: oscillator or pll input times multiplier
  assign pll_m = cfg_word[21:18];

  always_comb begin
    mul_b = 5'd1;
    if (cfg_word[1:0] == ccr_pkg::SEL_HSE) begin
      mul_a = hse_hz;
    end else if (cfg_word[1:0] == ccr_pkg::SEL_PLL) begin
      mul_a = cfg_word[16] ? hse_hz : {1'b0, hsi_hz[25:1]};
      mul_b = (pll_m == 4'd15) ? 5'd16 : (5'(pll_m) + 5'd2);
    end else begin
      mul_a = hsi_hz;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ccr_pkg::S_MUL) begin
      sys_hz <= 31'(mul_a) * 31'(mul_b);
    end
  end

  assign core_hz = sys_hz >> ccr_pkg::ahb_shift(cfg_word[7:4]);
  assign bus1_hz = core_hz >> ccr_pkg::apb_shift(cfg_word[10:8]);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.read_data     <= pend_rdata;
      rsp.status        <= pend_status;
      rsp.clock_changed <= pend_changed;
      rsp.backup_reset  <= pend_bkp;
      rsp.core_clock_hz <= {1'b0, core_hz};
      rsp.bus1_clock_hz <= {1'b0, bus1_hz};
    end
  end

  // checks
  a_accept_starts_read: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == ccr_pkg::S_READ)
    else $error("request transfer did not start a memory read");

  a_error_quiet: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ccr_pkg::STATUS_OK |->
      rsp.read_data == 32'd0 && !rsp.clock_changed && !rsp.backup_reset)
    else $error("error response carries data or pulses");

  a_pulse_only_on_write: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.clock_changed || rsp.backup_reset) |->
      rsp.status == ccr_pkg::STATUS_OK && rsp.read_data == 32'd0)
    else $error("pulse on a read or failed access");

  a_write_in_read_step: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> $past(req_valid && req_ready))
    else $error("shadow write without a preceding request transfer");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for clock_control_register_block: bus accesses through the request
// channel, results checked against an in-bench model of the shadow words and clock rates.
// Depends on ccr_pkg and the block itself; oscillator registers set over the APB port.
module tb;

  localparam int REGION_BYTES = 64;
  localparam logic [2:0] ADDR_INT_OSC = 3'd0;
  localparam logic [2:0] ADDR_EXT_OSC = 3'd4;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  ccr_pkg::req_t req = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  ccr_pkg::rsp_t rsp;
  logic          psel = 1'b0;
  logic          penable = 1'b0;
  logic          pwrite = 1'b0;
  logic [2:0]    paddr = '0;
  logic [31:0]   pwdata = '0;
  logic [31:0]   prdata;
  logic          pready;

  ccr_pkg::req_t access_q[$];
  ccr_pkg::rsp_t pending_results[$];
  ccr_pkg::rsp_t want;
  logic [31:0]   shadow[REGION_BYTES / 4];
  logic [25:0]   int_osc_hz = ccr_pkg::OSC_DEFAULT_HZ;
  logic [25:0]   ext_osc_hz = ccr_pkg::OSC_DEFAULT_HZ;
  int            idle_pct = 0;
  int            stall_pct = 0;
  logic          hold_go = 1'b0;
  logic          hold_rsp = 1'b0;
  int            queued_count = 0;
  int            accepted_count = 0;
  int            results_seen = 0;
  int            error_count = 0;
  int            settings_used = 1;

  clock_control_register_block #(.REGION_BYTES(REGION_BYTES)) DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic logic [31:0] readonly_bits(logic [9:0] word);
    if (word == ccr_pkg::WORD_CTRL) return ccr_pkg::READY_BITS;
    if (word == ccr_pkg::WORD_CFG) return ccr_pkg::SWS_BITS;
    return 32'd0;
  endfunction

  // updates the shadow words and returns the result the access should produce
  function automatic ccr_pkg::rsp_t bus_access_result(ccr_pkg::req_t r);
    ccr_pkg::rsp_t res;
    logic [9:0]    word;
    logic [4:0]    shift;
    logic [31:0]   v, old_v, mask, cfg, hsi, hse, sysclk, pin, mul, ahb_div, apb_div;
    res = '0;
    res.status = ccr_pkg::STATUS_OK;
    word = r.address[11:2];
    shift = {r.address[1:0], 3'b000};
    if (r.address >= REGION_BYTES) begin
      res.status = ccr_pkg::STATUS_BAD_OFFSET;
    end else if (r.access_size != ccr_pkg::SIZE_BYTE && r.access_size != ccr_pkg::SIZE_HALF &&
                 r.access_size != ccr_pkg::SIZE_WORD) begin
      res.status = ccr_pkg::STATUS_BAD_WIDTH;
    end else if (r.kind == ccr_pkg::KIND_READ) begin
      v = shadow[word];
      if (word == ccr_pkg::WORD_CTRL) begin
        v = v | ccr_pkg::READY_BITS;
      end else if (word == ccr_pkg::WORD_CFG) begin
        v = v & ~ccr_pkg::SWS_BITS;
        if (v[1:0] == ccr_pkg::SEL_PLL) v[3] = 1'b1;
        else if (v[1:0] == ccr_pkg::SEL_HSE) v[2] = 1'b1;
      end else if (word == ccr_pkg::WORD_BDCR || word == ccr_pkg::WORD_CSR) begin
        v = v | ccr_pkg::LOW_READY_BIT;
      end
      if (r.access_size == ccr_pkg::SIZE_BYTE) res.read_data = (v >> shift) & 32'hFF;
      else if (r.access_size == ccr_pkg::SIZE_HALF) res.read_data = (v >> shift) & 32'hFFFF;
      else res.read_data = v;
    end else begin
      old_v = shadow[word] & ~readonly_bits(word);
      if (r.access_size == ccr_pkg::SIZE_WORD) begin
        v = r.write_data;
      end else begin
        mask = ((r.access_size == ccr_pkg::SIZE_BYTE) ? 32'hFF : 32'hFFFF) << shift;
        v = (old_v & ~mask) | ((r.write_data << shift) & mask);
      end
      v = v & ~readonly_bits(word);
      shadow[word] = v;
      res.clock_changed = (word == ccr_pkg::WORD_CFG) &&
                          (((old_v ^ v) & ccr_pkg::CLOCK_BITS) != 0);
      res.backup_reset = (word == ccr_pkg::WORD_BDCR) && v[ccr_pkg::BACKUP_RESET_POS];
    end

    cfg = shadow[ccr_pkg::WORD_CFG];
    hsi = (int_osc_hz == 0) ? 32'(ccr_pkg::OSC_DEFAULT_HZ) : 32'(int_osc_hz);
    hse = (ext_osc_hz == 0) ? 32'(ccr_pkg::OSC_DEFAULT_HZ) : 32'(ext_osc_hz);
    if (cfg[1:0] == ccr_pkg::SEL_HSE) begin
      sysclk = hse;
    end else if (cfg[1:0] == ccr_pkg::SEL_PLL) begin
      mul = (cfg[21:18] == 4'd15) ? 32'd16 : 32'(cfg[21:18]) + 32'd2;
      pin = cfg[16] ? hse : hsi / 2;
      sysclk = pin * mul;
    end else begin
      sysclk = hsi;
    end
    unique case (cfg[7:4])
      4'd8:    ahb_div = 32'd2;
      4'd9:    ahb_div = 32'd4;
      4'd10:   ahb_div = 32'd8;
      4'd11:   ahb_div = 32'd16;
      4'd12:   ahb_div = 32'd64;
      4'd13:   ahb_div = 32'd128;
      4'd14:   ahb_div = 32'd256;
      4'd15:   ahb_div = 32'd512;
      default: ahb_div = 32'd1;
    endcase
    unique case (cfg[10:8])
      3'd4:    apb_div = 32'd2;
      3'd5:    apb_div = 32'd4;
      3'd6:    apb_div = 32'd8;
      3'd7:    apb_div = 32'd16;
      default: apb_div = 32'd1;
    endcase
    res.core_clock_hz = sysclk / ahb_div;
    res.bus1_clock_hz = res.core_clock_hz / apb_div;
    return res;
  endfunction

  function automatic void queue_access(ccr_pkg::req_t r);
    access_q.push_back(r);
    queued_count++;
  endfunction

  // mostly legal accesses inside the region, leaning on the config word
  function automatic ccr_pkg::req_t random_access();
    ccr_pkg::req_t r;
    logic [2:0] sizes[3];
    sizes = '{ccr_pkg::SIZE_BYTE, ccr_pkg::SIZE_HALF, ccr_pkg::SIZE_WORD};
    r.kind = ccr_pkg::kind_t'($urandom_range(0, 1));
    r.write_data = $urandom;
    if ($urandom_range(99) < 20) begin
      r.address = 12'($urandom_range(0, 4095));
      r.access_size = 3'($urandom_range(0, 7));
    end else begin
      r.access_size = sizes[$urandom_range(0, 2)];
      if ($urandom_range(99) < 45) r.address = 12'($urandom_range(4, 7));
      else r.address = 12'($urandom_range(0, REGION_BYTES - 1));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] exp_val);
    $display("mismatch at result %0d, %s: got %h, expected %h",
             results_seen, what, got, exp_val);
    error_count++;
  endtask

  task automatic wait_idle();
    while (accepted_count != queued_count || pending_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_osc(logic [2:0] addr, logic [25:0] hz);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= 32'(hz);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_INT_OSC) int_osc_hz = hz;
    else ext_osc_hz = hz;
  endtask

  task automatic run_phase(int idle, int stall, int count, logic [25:0] ihz,
                           logic [25:0] ehz);
    wait_idle();
    write_osc(ADDR_INT_OSC, ihz);
    write_osc(ADDR_EXT_OSC, ehz);
    settings_used++;
    idle_pct <= idle;
    stall_pct <= stall;
    repeat (count) queue_access(random_access());
  endtask

  // request side: one transfer per handshake, model updated on acceptance
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        pending_results.push_back(bus_access_result(req));
        accepted_count++;
      end
      if (!req_valid || req_ready) begin
        if (access_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          req <= access_q.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response side
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("transfer with nothing pending", rsp.read_data, 32'd0);
        end else begin
          want = pending_results.pop_front();
          if (rsp.read_data !== want.read_data)
            report_mismatch("read_data", rsp.read_data, want.read_data);
          if (rsp.status !== want.status)
            report_mismatch("status", 32'(rsp.status), 32'(want.status));
          if (rsp.clock_changed !== want.clock_changed)
            report_mismatch("clock_changed", 32'(rsp.clock_changed),
                            32'(want.clock_changed));
          if (rsp.backup_reset !== want.backup_reset)
            report_mismatch("backup_reset", 32'(rsp.backup_reset),
                            32'(want.backup_reset));
          if (rsp.core_clock_hz !== want.core_clock_hz)
            report_mismatch("core_clock_hz", rsp.core_clock_hz, want.core_clock_hz);
          if (rsp.bus1_clock_hz !== want.bus1_clock_hz)
            report_mismatch("bus1_clock_hz", rsp.bus1_clock_hz, want.bus1_clock_hz);
        end
        results_seen++;
      end
      rsp_ready <= !hold_rsp && ($urandom_range(99) >= stall_pct);
    end
  end

  // long receiver hold-off while the sender keeps offering
  initial begin
    wait (hold_go);
    hold_rsp <= 1'b1;
    repeat (300) @(posedge clk);
    hold_rsp <= 1'b0;
  end

  initial begin
    foreach (shadow[i]) shadow[i] = 32'd0;

    // directed accesses, default oscillators, no idling
    queue_access('{ccr_pkg::KIND_READ,  12'h000, ccr_pkg::SIZE_WORD, 32'h0});
    queue_access('{ccr_pkg::KIND_READ,  12'h004, ccr_pkg::SIZE_WORD, 32'h0});
    queue_access('{ccr_pkg::KIND_READ,  12'h020, ccr_pkg::SIZE_HALF, 32'h0});
    queue_access('{ccr_pkg::KIND_READ,  12'h025, ccr_pkg::SIZE_BYTE, 32'h0});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h000, ccr_pkg::SIZE_WORD, 32'hFFFF_FFFF});
    queue_access('{ccr_pkg::KIND_READ,  12'h000, ccr_pkg::SIZE_WORD, 32'h0});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h004, ccr_pkg::SIZE_WORD, 32'h0000_0002});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h006, ccr_pkg::SIZE_BYTE, 32'hFFFF_FF3F});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h004, ccr_pkg::SIZE_HALF, 32'h0000_07F2});
    queue_access('{ccr_pkg::KIND_READ,  12'h004, ccr_pkg::SIZE_WORD, 32'h0});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h006, ccr_pkg::SIZE_BYTE, 32'h0000_0000});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h007, ccr_pkg::SIZE_HALF, 32'hFFFF_FFFF});
    queue_access('{ccr_pkg::KIND_READ,  12'h007, ccr_pkg::SIZE_HALF, 32'h0});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h00A, ccr_pkg::SIZE_WORD, 32'hDEAD_BEEF});
    queue_access('{ccr_pkg::KIND_READ,  12'h009, ccr_pkg::SIZE_WORD, 32'h0});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h020, ccr_pkg::SIZE_WORD, 32'h0001_0000});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h022, ccr_pkg::SIZE_BYTE, 32'h0000_0000});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h040, ccr_pkg::SIZE_WORD, 32'hFFFF_FFFF});
    queue_access('{ccr_pkg::KIND_READ,  12'hFFF, 3'd3,               32'h0});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h004, 3'd0,               32'h0000_0001});
    queue_access('{ccr_pkg::KIND_READ,  12'h000, 3'd7,               32'h0});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h004, ccr_pkg::SIZE_WORD, 32'h0000_0001});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h004, ccr_pkg::SIZE_WORD, 32'h0000_0001});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h004, ccr_pkg::SIZE_WORD, 32'h0000_0003});
    queue_access('{ccr_pkg::KIND_WRITE, 12'h03C, ccr_pkg::SIZE_WORD, 32'hA5C3_0F81});
    queue_access('{ccr_pkg::KIND_READ,  12'h03F, ccr_pkg::SIZE_BYTE, 32'h0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    run_phase(0, 0, 300, 26'd0, 26'd0);
    run_phase(77, 0, 300, 26'd50000000, 26'd50000000);
    run_phase(0, 77, 300, 26'd1, 26'($urandom_range(0, 50000000)));
    hold_go <= 1'b1;
    run_phase(24, 24, 300, 26'($urandom_range(0, 50000000)),
              26'($urandom_range(0, 50000000)));
    wait_idle();

    $display("checked %0d of %0d accesses over %0d oscillator settings", results_seen,
             accepted_count, settings_used);
    $display("idling patterns: none, sender gaps, receiver stalls, both, long hold-off");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
